@@ design/polist_pkg.sv @@
// ----------------------------------------------------------------------------
// polist_pkg
// Shared types and constants for the positional ordered list engine.
// ----------------------------------------------------------------------------
package polist_pkg;

  localparam int OPCODE_W = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;

  // request opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_READ   = 3'd2,
    OP_FIND   = 3'd3,
    OP_DELETE = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  // broadcast command to every cell of the chain
  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_WRITE,   // cell at idx takes value
    CELL_INSERT,  // cell at idx takes value, cells above take left neighbor
    CELL_SHIFT,   // cells at idx and above take right neighbor
    CELL_READ,    // hit marks the cell at idx
    CELL_FIND     // hit marks cells below idx whose data equals value
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [VALUE_W-1:0] value;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_RESOLVE
  } state_t;

endpackage

@@ design/polist_cell.sv @@
// ----------------------------------------------------------------------------
// polist_cell
// One list slot: holds an entry, shifts with its neighbors, flags hits.
// ----------------------------------------------------------------------------
module polist_cell
  import polist_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int IDX_W = 7
) (
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic [IDX_W-1:0]   idx,
  input  logic [VALUE_W-1:0] left_data,
  input  logic [VALUE_W-1:0] right_data,
  output logic [VALUE_W-1:0] data,
  output logic               hit
);

  localparam logic [IDX_W-1:0] ME = IDX_W'(INDEX);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_WRITE: begin
        if (idx == ME) data <= ctl.value;
      end
      CELL_INSERT: begin
        if (idx == ME) data <= ctl.value;
        else if (ME > idx) data <= left_data;
      end
      CELL_SHIFT: begin
        if (ME >= idx) data <= right_data;
      end
      CELL_READ: begin
        hit <= (idx == ME);
      end
      CELL_FIND: begin
        hit <= (ME < idx) && (data == ctl.value);
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/polist_resolve.sv @@
// ----------------------------------------------------------------------------
// polist_resolve
// Collects cell hits: first hit position and the data of the hit cell.
// ----------------------------------------------------------------------------
module polist_resolve
  import polist_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IDX_W = 7
) (
  input  logic [DEPTH-1:0]   hit,
  input  logic [VALUE_W-1:0] cell_data [DEPTH],
  output logic [IDX_W-1:0]   first_pos,   // 1-based, 0 when no hit
  output logic [VALUE_W-1:0] hit_data
);

  always_comb begin
    first_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) first_pos = IDX_W'(i + 1);
    end
  end

  always_comb begin
    hit_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_data = hit_data | (cell_data[i] & {VALUE_W{hit[i]}});
    end
  end

endmodule

@@ design/positional_ordered_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// positional_ordered_list_engine_unit
// Bounded ordered list of signed 32-bit values addressed by 1-based position,
// kept in a chain of DEPTH cells.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  request  | req_valid/req_ready | opcode, position, remove_count, value
//  response | rsp_valid/rsp_ready | ok, read_value, found_position, item_count
//
//  A request is accepted in idle and answered from the resolve state. A
//  delete of a nonempty run first shifts the chain cells by one slot per
//  cycle in the shift state. Reset clears the occupancy and the control
//  state only; the entries are undefined until written. A stalled response
//  holds in the output register; the next request is still accepted, and
//  its result waits in the resolve state until the output register frees up.
// ----------------------------------------------------------------------------
module positional_ordered_list_engine_unit
  import polist_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  // request
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic [OPCODE_W-1:0]       opcode,
  input  logic [POS_W-1:0]          position,
  input  logic [POS_W-1:0]          remove_count,
  input  logic signed [VALUE_W-1:0] value,
  // response
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output logic                      ok,
  output logic signed [VALUE_W-1:0] read_value,
  output logic [POS_W-1:0]          found_position,
  output logic [POS_W-1:0]          item_count
);

  // count width and the common width for position / count compares
  localparam int CW = $clog2(DEPTH + 1);
  localparam int W  = (CW > POS_W) ? CW : POS_W;

  state_t           state, state_next;
  logic [CW-1:0]    occupancy, occupancy_next;
  logic [POS_W-1:0] shift_cnt, shift_cnt_next;
  logic [W-1:0]     shift_idx, shift_idx_next;
  op_t              op_r, op_r_next;
  logic             ok_r, ok_r_next;

  cell_ctl_t        ctl;
  logic [W-1:0]     ctl_idx;

  logic [VALUE_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]   cell_hit;
  logic [W-1:0]       first_pos;
  logic [VALUE_W-1:0] hit_data;

  logic             accept;
  logic             load_rsp;
  logic [W-1:0]     pos_w, occ_w;
  logic             full, pos_ok, del_ok;

  // ---------------------------------------------------------------- chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_W-1:0] left_in, right_in;
    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end
    // last cell keeps its own data on a shift; it is past the new end anyway
    if (g == DEPTH - 1) begin : g_last
      assign right_in = cell_data[g];
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end

    polist_cell #(
      .INDEX (g),
      .IDX_W (W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (ctl_idx),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[g]),
      .hit        (cell_hit[g])
    );
  end

  polist_resolve #(
    .DEPTH (DEPTH),
    .IDX_W (W)
  ) u_resolve (
    .hit       (cell_hit),
    .cell_data (cell_data),
    .first_pos (first_pos),
    .hit_data  (hit_data)
  );

  // ---------------------------------------------------------------- control
  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign load_rsp  = (state == ST_RESOLVE) && (!rsp_valid || rsp_ready);

  assign pos_w  = W'(position);
  assign occ_w  = W'(occupancy);
  assign full   = (occupancy == CW'(DEPTH));
  assign pos_ok = (pos_w != '0) && (pos_w <= occ_w);
  // start + run - 1 <= occupancy, kept one bit wider so it cannot wrap
  assign del_ok = pos_ok &&
                  (({1'b0, pos_w} + (W+1)'(remove_count)) <= ({1'b0, occ_w} + 1'b1));

  always_comb begin
    state_next     = state;
    occupancy_next = occupancy;
    shift_cnt_next = shift_cnt;
    shift_idx_next = shift_idx;
    op_r_next      = op_r;
    ok_r_next      = ok_r;
    ctl.op         = CELL_NOP;
    ctl.value      = value;
    ctl_idx        = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          op_r_next  = op_t'(opcode);
          state_next = ST_RESOLVE;
          case (op_t'(opcode))
            OP_APPEND: begin
              ok_r_next = !full;
              if (!full) begin
                ctl.op         = CELL_WRITE;
                ctl_idx        = occ_w;
                occupancy_next = occupancy + 1'b1;
              end
            end
            OP_INSERT: begin
              ok_r_next = pos_ok && !full;
              if (pos_ok && !full) begin
                ctl.op         = CELL_INSERT;
                ctl_idx        = pos_w - 1'b1;
                occupancy_next = occupancy + 1'b1;
              end
            end
            OP_READ: begin
              ok_r_next = pos_ok;
              ctl.op    = CELL_READ;
              ctl_idx   = pos_w - 1'b1;
            end
            OP_FIND: begin
              ok_r_next = 1'b1;
              ctl.op    = CELL_FIND;
              ctl_idx   = occ_w;
            end
            OP_DELETE: begin
              ok_r_next = del_ok;
              if (del_ok && (remove_count != '0)) begin
                occupancy_next = occupancy - CW'(remove_count);
                shift_cnt_next = remove_count;
                shift_idx_next = pos_w - 1'b1;
                state_next     = ST_SHIFT;
              end
            end
            OP_CLEAR: begin
              ok_r_next      = 1'b1;
              occupancy_next = '0;
            end
            default: begin
              ok_r_next = 1'b0;
            end
          endcase
        end
      end
      ST_SHIFT: begin
        // close the gap one slot per cycle
        ctl.op         = CELL_SHIFT;
        ctl_idx        = shift_idx;
        shift_cnt_next = shift_cnt - 1'b1;
        if (shift_cnt == POS_W'(1)) state_next = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (load_rsp) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occupancy <= '0;
      shift_cnt <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occupancy_next;
      shift_cnt <= shift_cnt_next;
      if (load_rsp) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    shift_idx <= shift_idx_next;
    op_r      <= op_r_next;
    ok_r      <= ok_r_next;
  end

  // response register: read data and find position come from the cell hits
  always_ff @(posedge clk) begin
    if (load_rsp) begin
      ok             <= ok_r;
      item_count     <= POS_W'(occupancy);
      found_position <= (op_r == OP_FIND) ? POS_W'(first_pos) : '0;
      if (op_r == OP_READ) read_value <= ok_r ? hit_data : '1;
      else read_value <= '0;
    end
  end

  // ---------------------------------------------------------------- checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CW'(DEPTH))
    else $error("occupancy above store depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && (opcode == OP_CLEAR) |=> occupancy == '0)
    else $error("clear left entries");

  a_shift_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> shift_cnt != '0)
    else $error("shift state with empty count");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (found_position != '0) |-> ok)
    else $error("find hit reported without ok");

endmodule

@@ test/positional_ordered_list_engine_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_ordered_list_engine_unit_tb
// Self-checking bench for the positional list engine. A short table of
// requests walks the reset state, the field extremes and most rejections.
// A long random stream follows, shaped to grow the list until it is full and
// then drain it. Each response is compared field by field with a shadow copy
// of the list, under several patterns of idle and stall on both channels.
// ----------------------------------------------------------------------------
module positional_ordered_list_engine_unit_tb
  import polist_pkg::*;
();

  localparam int DEPTH           = 64;
  localparam int RANDOM_PER_RUN  = 310;   // requests per random phase, 5 phases
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RUN_LIMIT_NS    = 5_000_000;
  localparam int REPORT_LINES    = 50;

  // opcodes the engine must reject
  localparam logic [OPCODE_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE7 = 3'd7;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  // how a table row is checked
  localparam logic ROW_MODEL = 1'b0;
  localparam logic ROW_TYPED = 1'b1;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic [POS_W-1:0]          position;
    logic [POS_W-1:0]          remove_count;
    logic signed [VALUE_W-1:0] value;
  } list_cmd_t;

  typedef struct packed {
    logic                      ok;
    logic signed [VALUE_W-1:0] read_value;
    logic [POS_W-1:0]          found_position;
    logic [POS_W-1:0]          item_count;
  } list_result_t;

  typedef struct packed {
    list_cmd_t    cmd;
    logic         typed;
    list_result_t want;
  } plan_row_t;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      req_valid    = 1'b0;
  logic                      req_ready;
  logic [OPCODE_W-1:0]       opcode       = '0;
  logic [POS_W-1:0]          position     = '0;
  logic [POS_W-1:0]          remove_count = '0;
  logic signed [VALUE_W-1:0] value        = '0;
  logic                      rsp_valid;
  logic                      rsp_ready    = 1'b0;
  logic                      ok;
  logic signed [VALUE_W-1:0] read_value;
  logic [POS_W-1:0]          found_position;
  logic [POS_W-1:0]          item_count;

  // shadow copy of the list
  logic signed [VALUE_W-1:0] shadow_slots [DEPTH];
  int                        shadow_fill = 0;

  list_result_t pending_results [$];
  plan_row_t    directed_plan [$];
  int           mismatches = 0;

  // idle pattern, set per phase by the stimulus process
  int gap_pct   = 0;
  int stall_pct = 0;
  int hold_off_starts = 0;

  positional_ordered_list_engine_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .opcode        (opcode),
    .position      (position),
    .remove_count  (remove_count),
    .value         (value),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .ok            (ok),
    .read_value    (read_value),
    .found_position(found_position),
    .item_count    (item_count)
  );

  always #5 clk = ~clk;

  // Shadow list update: one command in, the response it must produce out.
  function automatic list_result_t apply_list_command(input list_cmd_t c);
    list_result_t r;
    int p, n, i;
    r = '0;
    p = int'(c.position);
    n = int'(c.remove_count);
    case (c.opcode)
      OP_APPEND: begin
        if (shadow_fill < DEPTH) begin
          shadow_slots[shadow_fill] = c.value;
          shadow_fill++;
          r.ok = 1'b1;
        end
      end
      OP_INSERT: begin
        if (p >= 1 && p <= shadow_fill && shadow_fill < DEPTH) begin
          for (i = shadow_fill; i > p - 1; i--) shadow_slots[i] = shadow_slots[i-1];
          shadow_slots[p-1] = c.value;
          shadow_fill++;
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (p >= 1 && p <= shadow_fill) begin
          r.read_value = shadow_slots[p-1];
          r.ok = 1'b1;
        end else begin
          r.read_value = -1;
        end
      end
      OP_FIND: begin
        r.ok = 1'b1;
        for (i = 0; i < shadow_fill; i++) begin
          if (shadow_slots[i] == c.value) begin
            r.found_position = POS_W'(i + 1);
            break;
          end
        end
      end
      OP_DELETE: begin
        // whole run must lie inside the list, even an empty run needs a valid start
        if (p >= 1 && p <= shadow_fill && p + n - 1 <= shadow_fill) begin
          for (i = p - 1; i + n < shadow_fill; i++) shadow_slots[i] = shadow_slots[i+n];
          shadow_fill -= n;
          r.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        shadow_fill = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.item_count = POS_W'(shadow_fill);
    return r;
  endfunction

  // Random request, mostly aimed at positions and runs inside the current list.
  function automatic list_cmd_t random_list_command(input bit grow);
    list_cmd_t c;
    int pick, span, sel;
    c.opcode       = OPCODE_W'($urandom_range(7));
    c.position     = POS_W'($urandom_range(127));
    c.remove_count = POS_W'($urandom_range(127));
    c.value        = $urandom;
    if ($urandom_range(99) < 6) return c;   // noise

    pick = $urandom_range(99);
    if (grow) begin
      if (pick < 45)      c.opcode = OP_APPEND;
      else if (pick < 65) c.opcode = OP_INSERT;
      else if (pick < 77) c.opcode = OP_READ;
      else if (pick < 90) c.opcode = OP_FIND;
      else                c.opcode = OP_DELETE;
    end else begin
      if (pick < 15)      c.opcode = OP_APPEND;
      else if (pick < 25) c.opcode = OP_INSERT;
      else if (pick < 40) c.opcode = OP_READ;
      else if (pick < 55) c.opcode = OP_FIND;
      else if (pick < 96) c.opcode = OP_DELETE;
      else                c.opcode = OP_CLEAR;
    end

    sel = $urandom_range(99);
    if (shadow_fill > 0 && sel < 80) begin
      c.position = POS_W'($urandom_range(shadow_fill, 1));
    end else if (sel < 90) begin
      case ($urandom_range(2))
        0:       c.position = '0;
        1:       c.position = POS_W'(shadow_fill);
        default: c.position = POS_W'(shadow_fill + 1);
      endcase
    end

    span = shadow_fill - int'(c.position) + 1;
    if (span > 0) begin
      sel = $urandom_range(99);
      if (sel < 60)      c.remove_count = POS_W'($urandom_range((span < 4) ? span : 4, 0));
      else if (sel < 75) c.remove_count = POS_W'(span);      // up to the tail
      else if (sel < 85) c.remove_count = POS_W'(span + 1);  // one past the tail
      else if (sel < 92) c.remove_count = '0;
    end

    sel = $urandom_range(99);
    if (c.opcode == OP_FIND && shadow_fill > 0 && sel < 60) begin
      c.value = shadow_slots[$urandom_range(shadow_fill - 1, 0)];
    end else if (sel < 40) begin
      c.value = $signed($urandom_range(7)) - 4;          // small pool, many repeats
    end else if (sel < 50) begin
      case ($urandom_range(3))
        0:       c.value = VAL_MAX;
        1:       c.value = VAL_MIN;
        2:       c.value = 0;
        default: c.value = -1;
      endcase
    end
    return c;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < REPORT_LINES)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    mismatches++;
  endtask

  // Offer one request, wait for its acceptance, then queue its response.
  task automatic send_request(input list_cmd_t c, input logic typed,
                              input list_result_t want);
    list_result_t predicted;
    if ($urandom_range(99) < gap_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    req_valid    <= 1'b1;
    opcode       <= c.opcode;
    position     <= c.position;
    remove_count <= c.remove_count;
    value        <= c.value;
    do @(posedge clk); while (!req_ready);
    predicted = apply_list_command(c);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic add_row(input logic [OPCODE_W-1:0] op, input int pos, input int rcnt,
                         input logic signed [VALUE_W-1:0] val, input logic typed,
                         input logic w_ok, input logic signed [VALUE_W-1:0] w_rd,
                         input int w_found, input int w_count);
    plan_row_t row;
    row.cmd.opcode               = op;
    row.cmd.position             = POS_W'(pos);
    row.cmd.remove_count         = POS_W'(rcnt);
    row.cmd.value                = val;
    row.typed                    = typed;
    row.want.ok                  = w_ok;
    row.want.read_value          = w_rd;
    row.want.found_position      = POS_W'(w_found);
    row.want.item_count          = POS_W'(w_count);
    directed_plan.push_back(row);
  endtask

  // Response side: random stall, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    static int hold_left = 0;
    static int hold_off_seen = 0;
    if (hold_off_starts != hold_off_seen) begin
      hold_off_seen = hold_off_starts;
      hold_left     = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      rsp_ready <= 1'b0;
      hold_left--;
    end else begin
      rsp_ready <= !rst && ($urandom_range(99) >= stall_pct);
    end
  end

  // Response checker: oldest waiting response first.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("response with no request waiting", 32'(item_count), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (ok !== want.ok) report_mismatch("ok", 32'(ok), 32'(want.ok));
        if (read_value !== want.read_value)
          report_mismatch("read_value", read_value, want.read_value);
        if (found_position !== want.found_position)
          report_mismatch("found_position", 32'(found_position),
                          32'(want.found_position));
        if (item_count !== want.item_count)
          report_mismatch("item_count", 32'(item_count), 32'(want.item_count));
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  initial begin
    plan_row_t row;
    list_cmd_t c;
    int phase, full_run;
    bit grow;

    //      opcode      pos  rcnt value    check      ok  read_value fp  count
    add_row(OP_READ,     1,   0,  0,       ROW_TYPED, 0,  -1,        0,  0);  // empty list
    add_row(OP_FIND,     0,   0,  0,       ROW_TYPED, 1,  0,         0,  0);
    add_row(OP_INSERT,   1,   0,  9,       ROW_TYPED, 0,  0,         0,  0);
    add_row(OP_DELETE,   1,   0,  0,       ROW_TYPED, 0,  0,         0,  0);  // no start
    add_row(OP_APPEND,   0,   0,  VAL_MAX, ROW_TYPED, 1,  0,         0,  1);
    add_row(OP_APPEND,   127, 127, VAL_MIN, ROW_TYPED, 1, 0,         0,  2);
    add_row(OP_APPEND,   0,   0,  -1,      ROW_TYPED, 1,  0,         0,  3);
    add_row(OP_APPEND,   0,   0,  0,       ROW_TYPED, 1,  0,         0,  4);
    add_row(OP_INSERT,   1,   0,  5,       ROW_MODEL, 0,  0,         0,  0);  // at the head
    add_row(OP_INSERT,   5,   0,  7,       ROW_MODEL, 0,  0,         0,  0);  // before tail
    add_row(OP_INSERT,   0,   0,  3,       ROW_TYPED, 0,  0,         0,  6);
    add_row(OP_INSERT,   7,   0,  3,       ROW_TYPED, 0,  0,         0,  6);  // past tail
    add_row(OP_READ,     0,   0,  0,       ROW_TYPED, 0,  -1,        0,  6);
    add_row(OP_READ,     127, 0,  0,       ROW_TYPED, 0,  -1,        0,  6);
    add_row(OP_READ,     1,   0,  0,       ROW_MODEL, 0,  0,         0,  0);
    add_row(OP_READ,     6,   0,  0,       ROW_MODEL, 0,  0,         0,  0);
    add_row(OP_FIND,     0,   0,  VAL_MIN, ROW_MODEL, 0,  0,         0,  0);
    add_row(OP_FIND,     0,   0,  12345,   ROW_TYPED, 1,  0,         0,  6);  // absent
    add_row(OP_DELETE,   2,   0,  0,       ROW_TYPED, 1,  0,         0,  6);  // empty run
    add_row(OP_DELETE,   3,   127, 0,      ROW_TYPED, 0,  0,         0,  6);
    add_row(OP_DELETE,   5,   3,  0,       ROW_TYPED, 0,  0,         0,  6);  // runs off end
    add_row(OP_DELETE,   2,   2,  0,       ROW_MODEL, 0,  0,         0,  0);
    add_row(OP_SPARE6,   1,   1,  1,       ROW_TYPED, 0,  0,         0,  4);
    add_row(OP_SPARE7,   127, 127, -1,     ROW_TYPED, 0,  0,         0,  4);
    add_row(OP_CLEAR,    0,   0,  0,       ROW_TYPED, 1,  0,         0,  0);
    add_row(OP_READ,     1,   0,  0,       ROW_TYPED, 0,  -1,        0,  0);  // after clear

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[k]) begin
      row = directed_plan[k];
      send_request(row.cmd, row.typed, row.want);
    end

    // Random phases: none, sender idle, receiver stall, both, none again.
    // The list grows until it has sat full for a while, then drains.
    grow = 1'b1;
    full_run = 0;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        1:       begin gap_pct = 45; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 45; end
        3:       begin gap_pct = 35; stall_pct = 35; end
        default: begin gap_pct = 0;  stall_pct = 0;  end
      endcase
      // long response hold-off while requests keep coming: engine must back up
      if (phase == 0 || phase == 4) hold_off_starts++;
      repeat (RANDOM_PER_RUN) begin
        if (shadow_fill == DEPTH) full_run++;
        if (grow && full_run > 20) begin
          grow = 1'b0;
          full_run = 0;
        end else if (!grow && shadow_fill < 6) begin
          grow = 1'b1;
        end
        c = random_list_command(grow);
        send_request(c, ROW_MODEL, '0);
      end
    end
    req_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);   // room for a stray late response

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ positional_ordered_list_engine_unit.f @@
design/polist_pkg.sv
design/polist_cell.sv
design/polist_resolve.sv
design/positional_ordered_list_engine_unit.sv
test/positional_ordered_list_engine_unit_tb.sv
